/* hdl/npcm_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest palette color mapper package
// Shared constants and word types for the palette mapper and its channels.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int SIZE_W            = 9;
    localparam int CHAN_W            = 8;
    localparam int SLOT_W            = 8;
    localparam int DIST_W            = 10;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

endpackage

/* hdl/npcm_if.sv */
// ----------------------------------------------------------------------------
// Nearest palette color mapper channels
// Valid/ready channels for input words (entry writes and pixels) and results.
// ----------------------------------------------------------------------------
interface npcm_in_if
    import npcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SLOT_W-1:0] entry_index;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;

    modport source (
        output valid, operation, entry_index, in_red, in_green, in_blue, in_alpha,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, in_red, in_green, in_blue, in_alpha,
        output ready
    );
endinterface

interface npcm_out_if
    import npcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              exact_hit;
    logic [SLOT_W-1:0] chosen_slot;
    logic [DIST_W-1:0] best_distance;
    logic              palette_empty;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, exact_hit,
               chosen_slot, best_distance, palette_empty,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, exact_hit,
               chosen_slot, best_distance, palette_empty,
        output ready
    );
endinterface

/* hdl/nearest_palette_color_mapper.sv */
// ----------------------------------------------------------------------------
// Nearest palette color mapper
// Stores RGBA palette entries and maps each pixel onto an exact match or the
// entry at least L1 RGB distance, lowest index on ties.
//
//   Channel   Dir  Handshake          Contents
//   i_in      in   valid/ready        operation, entry_index, RGBA
//   o_out     out  valid/ready        RGBA, exact_hit, chosen_slot, distance
//   i_cfg_*   in   write enable       palette_size
//
// A write word is stored as it is accepted. A pixel word is searched over the N
// active palette entries, one shared compare unit visiting one entry a cycle
// from the single memory read port; an empty palette skips the search.
// Reset is synchronous and active low; the palette contents stay undefined.
// The result register lets the next word be accepted while a result waits;
// a finished search holds until the result register is free.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    npcm_in_if.sink           i_in,
    npcm_out_if.source        o_out
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_cfg_size;
    logic [31:0]       r_mem [PALETTE_DEPTH];
    logic [31:0]       r_rd_data;
    logic [AW-1:0]     r_rd_idx;
    logic              r_rd_vld;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_last_addr;
    logic [31:0]       r_pix;
    logic              r_empty;
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [DIST_W-1:0] r_best;
    logic [AW-1:0]     r_best_idx;
    logic [31:0]       r_best_entry;

    logic [31:0]       w_pix;
    logic [CW-1:0]     w_active;
    logic              w_accept;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [31:0]       w_idx32;
    logic [CHAN_W-1:0] w_dr;
    logic [CHAN_W-1:0] w_dg;
    logic [CHAN_W-1:0] w_db;
    logic [DIST_W-1:0] w_dist;
    logic              w_exact;
    logic [AW-1:0]     w_sel_idx;
    logic [31:0]       w_slot32;

    assign w_pix    = {i_in.in_red, i_in.in_green, i_in.in_blue, i_in.in_alpha};
    assign w_active = (32'(r_cfg_size) > 32'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                             : CW'(r_cfg_size);
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_idx32    = 32'(i_in.entry_index);
    assign w_wr_addr  = w_idx32[AW-1:0];
    assign w_wr_en    = w_accept && (i_in.operation == OP_WRITE)
                        && (w_idx32 < 32'(PALETTE_DEPTH));

    always_comb begin
        w_dr = (r_pix[31:24] > r_rd_data[31:24]) ? r_pix[31:24] - r_rd_data[31:24]
                                                 : r_rd_data[31:24] - r_pix[31:24];
        w_dg = (r_pix[23:16] > r_rd_data[23:16]) ? r_pix[23:16] - r_rd_data[23:16]
                                                 : r_rd_data[23:16] - r_pix[23:16];
        w_db = (r_pix[15:8] > r_rd_data[15:8]) ? r_pix[15:8] - r_rd_data[15:8]
                                               : r_rd_data[15:8] - r_pix[15:8];
        w_dist  = DIST_W'(w_dr) + DIST_W'(w_dg) + DIST_W'(w_db);
        w_exact = (r_rd_data == r_pix);
    end

    assign w_sel_idx = r_hit ? r_hit_idx : r_best_idx;
    assign w_slot32  = 32'(w_sel_idx);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_pix;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_size  <= '0;
            r_rd_vld    <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_size <= i_cfg_wdata;
            end
            if (o_out.valid && o_out.ready && (r_state != S_FIN)) begin
                o_out.valid <= 1'b0;
            end
            if (r_rd_vld) begin
                if (w_exact && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (w_dist < r_best) begin
                    r_best       <= w_dist;
                    r_best_idx   <= r_rd_idx;
                    r_best_entry <= r_rd_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (w_accept && (i_in.operation == OP_PIXEL)) begin
                        r_pix       <= w_pix;
                        r_addr      <= '0;
                        r_hit       <= 1'b0;
                        r_hit_idx   <= '0;
                        r_best      <= '1;
                        r_best_idx  <= '0;
                        r_empty     <= (w_active == '0);
                        r_last_addr <= AW'(w_active - CW'(1));
                        r_state     <= (w_active == '0) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_addr;
                    r_addr   <= r_addr + AW'(1);
                    if (r_addr == r_last_addr) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_rd_vld <= 1'b0;
                    if (!o_out.valid || o_out.ready) begin
                        o_out.valid         <= 1'b1;
                        o_out.palette_empty <= r_empty;
                        o_out.exact_hit     <= !r_empty && r_hit;
                        if (r_empty || r_hit) begin
                            {o_out.out_red, o_out.out_green,
                             o_out.out_blue, o_out.out_alpha} <= r_pix;
                            o_out.best_distance <= '0;
                        end else begin
                            {o_out.out_red, o_out.out_green,
                             o_out.out_blue, o_out.out_alpha} <= r_best_entry;
                            o_out.best_distance <= r_best;
                        end
                        o_out.chosen_slot <= r_empty ? '0 : w_slot32[SLOT_W-1:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rd_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("Compare word outside of a search.");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_last_addr))
        else $error("Search address passed the last active entry.");

    a_hit_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.exact_hit) |-> (o_out.best_distance == '0))
        else $error("Exact hit with a nonzero distance.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.palette_empty)
            |-> (!o_out.exact_hit && o_out.chosen_slot == '0))
        else $error("Empty palette result carries a hit or a slot.");

    a_empty_skips_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == OP_PIXEL && w_active == '0)
            |=> (r_state == S_FIN))
        else $error("Empty palette pixel entered a search.");

endmodule

/* tb/nearest_palette_color_mapper_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest palette color mapper testbench
// Loads palette entries and maps pixels through the valid/ready channels while
// the palette size is changed between phases. A local copy of the palette predicts
// each pixel that has no listed result (exact hit, nearest entry by L1 RGB
// distance with the lowest index on ties, or an empty palette), and each result
// word is compared field by field. Both channels idle at random, and the
// receiver twice holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_tb;
    import npcm_pkg::*;

    localparam int DEPTH      = PALETTE_DEPTH_DEF;
    localparam int NUM_PHASES = 16;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
    } t_rgba;

    typedef struct packed {
        t_rgba             px;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] distance;
        logic              empty;
    } t_map_result;

    typedef struct {
        t_op               op;
        logic [SLOT_W-1:0] idx;
        t_rgba             px;
    } t_word;

    typedef enum {ROW_SIZE, ROW_WORD} t_row_kind;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        t_row_kind   kind;
        int          size_val;
        t_word       w;
        bit          has_exp;
        t_map_result exp;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    npcm_in_if  in_if();
    npcm_out_if out_if();

    nearest_palette_color_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_rgba             palette_copy[DEPTH];
    logic [SIZE_W-1:0] size_copy = '0;
    t_map_result       expected_maps[$];
    int                fail_count = 0;
    int                tx_pct = 0;
    int                rx_pct = 0;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                hold_left = 0;
    int                phase_sizes[NUM_PHASES] =
        '{256, 1, 2, 5, 16, 511, 0, 7, 64, 3, 300, 12, 1, 4, 33, 9};
    t_dir_row          dir_rows[$];

    function automatic int chan_diff(logic [CHAN_W-1:0] x, logic [CHAN_W-1:0] y);
        return (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
    endfunction

    function automatic t_map_result map_pixel(t_rgba px);
        t_map_result res;
        int          n;
        int          d;
        int          best;
        res    = '0;
        res.px = px;
        n      = (size_copy > DEPTH) ? DEPTH : int'(size_copy);
        if (n == 0) begin
            res.empty = 1'b1;
            return res;
        end
        for (int i = 0; i < n; i++) begin
            if (palette_copy[i] == px) begin
                res.hit  = 1'b1;
                res.slot = SLOT_W'(i);
                return res;
            end
        end
        best = 1 << 30;
        for (int i = 0; i < n; i++) begin
            d = chan_diff(px.r, palette_copy[i].r) + chan_diff(px.g, palette_copy[i].g)
              + chan_diff(px.b, palette_copy[i].b);
            if (d < best) begin
                best     = d;
                res.slot = SLOT_W'(i);
            end
        end
        res.px       = palette_copy[res.slot];
        res.distance = DIST_W'(best);
        return res;
    endfunction

    function automatic t_map_result mk_exp(t_rgba px, bit hit, int slot, int dist_val,
                                           bit empty);
        t_map_result res;
        res.px       = px;
        res.hit      = hit;
        res.slot     = SLOT_W'(slot);
        res.distance = DIST_W'(dist_val);
        res.empty    = empty;
        return res;
    endfunction

    function automatic t_dir_row mk_row(t_op op, int idx, t_rgba px, bit has_exp = 1'b0,
                                        t_map_result exp = '0);
        t_dir_row row;
        row.kind     = ROW_WORD;
        row.size_val = 0;
        row.w.op     = op;
        row.w.idx    = SLOT_W'(idx);
        row.w.px     = px;
        row.has_exp  = has_exp;
        row.exp      = exp;
        return row;
    endfunction

    function automatic t_dir_row mk_size(int val);
        t_dir_row row;
        row          = mk_row(OP_WRITE, 0, '0);
        row.kind     = ROW_SIZE;
        row.size_val = val;
        return row;
    endfunction

    function automatic void check_field(string name, int exp, int act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    task automatic push_word(t_word w, bit has_exp = 1'b0, t_map_result exp = '0);
        while ($urandom_range(99) < tx_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= w.op;
        in_if.entry_index <= w.idx;
        in_if.in_red      <= w.px.r;
        in_if.in_green    <= w.px.g;
        in_if.in_blue     <= w.px.b;
        in_if.in_alpha    <= w.px.a;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        if (w.op == OP_WRITE) begin
            palette_copy[w.idx] = w.px;
        end else begin
            expected_maps.push_back(has_exp ? exp : map_pixel(w.px));
        end
    endtask

    task automatic set_size(int val);
        int n;
        n = (size_copy > DEPTH) ? DEPTH : int'(size_copy);
        in_if.valid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (n + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SIZE_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_copy = SIZE_W'(val);
    endtask

    task automatic run_phase(int size_val, t_idle_mode mode, int count, bit with_hold);
        int    n;
        int    lim;
        int    src;
        int    k;
        t_word w;
        t_rgba px;
        set_size(size_val);
        case (mode)
            IDLE_NONE: begin
                tx_pct = 0;
                rx_pct = 0;
            end
            IDLE_SENDER: begin
                tx_pct = 62;
                rx_pct = 0;
            end
            IDLE_RECEIVER: begin
                tx_pct = 0;
                rx_pct = 62;
            end
            default: begin
                tx_pct = 28;
                rx_pct = 28;
            end
        endcase
        if (with_hold) hold_requests++;
        n   = (size_val > DEPTH) ? DEPTH : size_val;
        lim = (n > 0) ? n : DEPTH;
        repeat (count) begin
            w.idx = SLOT_W'($urandom_range(255));
            w.px  = $urandom();
            src   = $urandom_range(lim - 1);
            if ($urandom_range(3) != 0) begin
                w.op = OP_PIXEL;
                if (n > 0) begin
                    case ($urandom_range(9))
                        0, 1, 2: w.px = palette_copy[src];
                        3, 4: begin
                            px   = palette_copy[src];
                            px.a = w.px.a;
                            w.px = px;
                        end
                        5, 6: w.px = palette_copy[src] ^ ($urandom() & 32'h0303_0303);
                        default: ;
                    endcase
                end
            end else begin
                w.op = OP_WRITE;
                if (n > 0 && $urandom_range(3) != 0) w.idx = SLOT_W'($urandom_range(n - 1));
                k = $urandom_range(9);
                if (k < 3) begin
                    px   = palette_copy[src];
                    px.a = w.px.a;
                    w.px = px;
                end else if (k < 5) begin
                    w.px.r = $urandom_range(1) ? 8'hFF : 8'h00;
                    w.px.g = $urandom_range(1) ? 8'hFF : 8'h00;
                    w.px.b = $urandom_range(1) ? 8'hFF : 8'h00;
                    w.px.a = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            end
            push_word(w);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_map_result exp;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_maps.size() == 0) begin
                $error("result word with no pixel outstanding");
                fail_count++;
            end else begin
                exp = expected_maps.pop_front();
                check_field("out_red", exp.px.r, out_if.out_red);
                check_field("out_green", exp.px.g, out_if.out_green);
                check_field("out_blue", exp.px.b, out_if.out_blue);
                check_field("out_alpha", exp.px.a, out_if.out_alpha);
                check_field("exact_hit", exp.hit, out_if.exact_hit);
                check_field("chosen_slot", exp.slot, out_if.chosen_slot);
                check_field("best_distance", exp.distance, out_if.best_distance);
                check_field("palette_empty", exp.empty, out_if.palette_empty);
            end
        end
    end

    initial begin
        t_word w;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.operation   = OP_WRITE;
        in_if.entry_index = '0;
        in_if.in_red      = '0;
        in_if.in_green    = '0;
        in_if.in_blue     = '0;
        in_if.in_alpha    = '0;

        // An empty palette passes pixels through; slot 0 and slot 2 share RGB.
        dir_rows = '{
            mk_row(OP_PIXEL, 0, 32'hFF00807F, 1, mk_exp(32'hFF00807F, 0, 0, 0, 1)),
            mk_row(OP_PIXEL, 255, 32'h00000000, 1, mk_exp(32'h00000000, 0, 0, 0, 1)),
            mk_row(OP_WRITE, 0, 32'h10203040),
            mk_row(OP_WRITE, 1, 32'hFFFFFFFF),
            mk_row(OP_WRITE, 2, 32'h10203099),
            mk_row(OP_WRITE, 255, 32'h00000000),
            mk_size(1),
            mk_row(OP_PIXEL, 0, 32'h10203040, 1, mk_exp(32'h10203040, 1, 0, 0, 0)),
            mk_row(OP_PIXEL, 0, 32'h00000000, 1, mk_exp(32'h10203040, 0, 0, 96, 0)),
            mk_row(OP_PIXEL, 0, 32'hFFFFFFFF),
            mk_size(3),
            mk_row(OP_PIXEL, 0, 32'h10203099, 1, mk_exp(32'h10203099, 1, 2, 0, 0)),
            mk_row(OP_PIXEL, 0, 32'h10203000, 1, mk_exp(32'h10203040, 0, 0, 0, 0)),
            mk_row(OP_PIXEL, 0, 32'hFFFFFF00),
            mk_row(OP_PIXEL, 0, 32'h80808080),
            mk_row(OP_WRITE, 1, 32'h10203040),
            mk_row(OP_PIXEL, 0, 32'h10203040, 1, mk_exp(32'h10203040, 1, 0, 0, 0)),
            mk_row(OP_PIXEL, 0, 32'hFE017F00),
            mk_size(0),
            mk_row(OP_PIXEL, 0, 32'h12345678, 1, mk_exp(32'h12345678, 0, 0, 0, 1))
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SIZE) begin
                set_size(dir_rows[i].size_val);
            end else begin
                push_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
            end
        end

        tx_pct = 28;
        for (int i = 0; i < DEPTH; i++) begin
            w.op  = OP_WRITE;
            w.idx = SLOT_W'(i);
            w.px  = $urandom();
            push_word(w);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(phase_sizes[p], t_idle_mode'(p % 4), (phase_sizes[p] >= 64) ? 40 : 130,
                      (p == 1 || p == 12));
        end

        in_if.valid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
